// ===== hdl/i2cso_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C slave offset register port package
// Event codes, register indexes, reset values and sizes shared by the block
// and its checker.
// ----------------------------------------------------------------------------
package i2cso_pkg;

  localparam int MAX_WRITE_BYTES = 4;
  localparam int WBUF_DEPTH      = 4;

  // bus_event codes
  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_START = 3'd1;
  localparam logic [2:0] EV_STOP  = 3'd2;
  localparam logic [2:0] EV_TMO   = 3'd3;
  localparam logic [2:0] EV_ADDR  = 3'd4;
  localparam logic [2:0] EV_NACK  = 3'd5;

  // configuration register indexes
  localparam logic CFG_SLAVE_ADDRESS   = 1'b0;
  localparam logic CFG_TIMEOUT_SAMPLES = 1'b1;

  localparam logic [6:0]  SLAVE_ADDRESS_RST   = 7'd80;
  localparam logic [23:0] TIMEOUT_SAMPLES_RST = 24'd1250000;
  localparam logic [23:0] STALL_MAX           = 24'hFFFFFF;

endpackage

// ===== hdl/i2c_slave_offset_register_port.sv =====
// ----------------------------------------------------------------------------
// I2C slave offset register port
// Oversampled I2C slave: one SCL/SDA sample per input word, one result word
// per sample carrying the SDA drive, bus event and write commit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, scl, sda) takes one line sample per
//   word, normally every clock from the synchronizers. Each sample yields
//   exactly one result word on the output channel (out_valid/out_ready).
//   Configuration words (cfg_valid/cfg_ready, cfg_index, cfg_data) set the
//   slave address (index 0) and the SCL stall timeout (index 1); cfg_ready is
//   always high. Write them only while the bus path is idle.
//   A result is registered in the result register, or in the skid register
//   while the output stalls. One sample per cycle while in_ready is high;
//   the bus state update is one pass of logic into state and result registers.
//   A two-entry output stage (result register plus skid register) keeps
//   in_ready high while one result waits; in_ready drops for as long as the
//   skid register holds a word, that is while both entries are full.
//   Reset returns the bus state to idle with both lines seen high, restores
//   the register reset values and empties the output stage.
// ----------------------------------------------------------------------------
module i2c_slave_offset_register_port (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        scl,
  input  logic        sda,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        sda_pull_low,
  output logic [2:0]  bus_event,
  output logic        commit_valid,
  output logic [7:0]  commit_offset,
  output logic [2:0]  commit_count,
  output logic [31:0] commit_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_ADDR, PH_ADDR_ACK, PH_WRITE, PH_WRITE_ACK, PH_READ, PH_READ_ACK
  } phase_t;

  typedef struct packed {
    logic        sda_pull_low;
    logic [2:0]  bus_event;
    logic        commit_valid;
    logic [7:0]  commit_offset;
    logic [2:0]  commit_count;
    logic [31:0] commit_bytes;
  } result_t;

  // configuration
  logic [6:0]  slave_address;
  logic [23:0] timeout_samples;

  // bus state
  phase_t      phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic        read_direction, read_direction_next;
  logic [7:0]  offset_reg, offset_reg_next;
  logic        offset_seen, offset_seen_next;
  logic [7:0]  start_offset, start_offset_next;
  logic [2:0]  buffer_count, buffer_count_next;
  logic [7:0]  write_buffer [i2cso_pkg::WBUF_DEPTH];
  logic [23:0] stall_counter, stall_counter_next;
  logic [1:0]  last_lines;

  logic        wbuf_we;
  logic [1:0]  wbuf_idx;
  logic        accept;
  result_t     res, out_reg, skid_reg;
  logic        skid_valid;
  logic        out_free;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !skid_valid;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    logic        pscl;
    logic        psda;
    logic [23:0] stall_inc;
    pscl = last_lines[1];
    psda = last_lines[0];
    stall_inc = (stall_counter == i2cso_pkg::STALL_MAX) ? stall_counter
                                                         : stall_counter + 24'd1;

    phase_next          = phase;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    read_direction_next = read_direction;
    offset_reg_next     = offset_reg;
    offset_seen_next    = offset_seen;
    start_offset_next   = start_offset;
    buffer_count_next   = buffer_count;
    stall_counter_next  = stall_counter;
    wbuf_we             = 1'b0;
    wbuf_idx            = buffer_count[1:0];
    res                 = '0;
    res.bus_event       = i2cso_pkg::EV_NONE;

    if (pscl && scl && psda && !sda) begin
      // start condition
      res.bus_event      = i2cso_pkg::EV_START;
      offset_seen_next   = 1'b0;
      buffer_count_next  = '0;
      phase_next         = PH_ADDR;
      bit_count_next     = '0;
      shift_byte_next    = '0;
      stall_counter_next = '0;
    end else if (pscl && scl && !psda && sda) begin
      // stop condition: commit pending write data
      res.bus_event = i2cso_pkg::EV_STOP;
      if (offset_seen) begin
        res.commit_valid  = 1'b1;
        res.commit_offset = start_offset;
        res.commit_count  = buffer_count;
        for (int i = 0; i < i2cso_pkg::WBUF_DEPTH; i++) begin
          if (3'(i) < buffer_count) begin
            res.commit_bytes[8*i +: 8] = write_buffer[i];
          end
        end
      end
      offset_seen_next   = 1'b0;
      buffer_count_next  = '0;
      phase_next         = PH_IDLE;
      stall_counter_next = '0;
    end else if (pscl != scl) begin
      stall_counter_next = '0;
      if (scl) begin
        // rising edge: sample data
        if (phase == PH_ADDR || phase == PH_WRITE) begin
          if (bit_count < 4'd8) begin
            shift_byte_next = {shift_byte[6:0], sda};
            bit_count_next  = bit_count + 4'd1;
          end
        end else if (phase == PH_READ_ACK) begin
          shift_byte_next = {7'd0, sda};
        end
      end else begin
        // falling edge: advance the transfer
        unique case (phase)
          PH_ADDR: begin
            if (bit_count >= 4'd8) begin
              if (shift_byte[7:1] == slave_address) begin
                read_direction_next = shift_byte[0];
                offset_seen_next    = 1'b0;
                buffer_count_next   = '0;
                phase_next          = PH_ADDR_ACK;
                res.bus_event       = i2cso_pkg::EV_ADDR;
              end else begin
                phase_next = PH_IDLE;
              end
            end
          end
          PH_ADDR_ACK: begin
            bit_count_next = '0;
            if (read_direction) begin
              shift_byte_next = offset_reg;
              phase_next      = PH_READ;
            end else begin
              shift_byte_next = '0;
              phase_next      = PH_WRITE;
            end
          end
          PH_WRITE: begin
            if (bit_count >= 4'd8) phase_next = PH_WRITE_ACK;
          end
          PH_WRITE_ACK: begin
            if (!offset_seen) begin
              offset_reg_next   = shift_byte;
              start_offset_next = shift_byte;
              offset_seen_next  = 1'b1;
            end else begin
              // drop bytes past the buffer, keep counting the offset
              if (buffer_count < 3'(i2cso_pkg::MAX_WRITE_BYTES)) begin
                wbuf_we           = 1'b1;
                buffer_count_next = buffer_count + 3'd1;
              end
              offset_reg_next = offset_reg + 8'd1;
            end
            bit_count_next  = '0;
            shift_byte_next = '0;
            phase_next      = PH_WRITE;
          end
          PH_READ: begin
            shift_byte_next = {shift_byte[6:0], 1'b0};
            bit_count_next  = bit_count + 4'd1;
            if (bit_count_next >= 4'd8) phase_next = PH_READ_ACK;
          end
          PH_READ_ACK: begin
            if (shift_byte == 8'd0) begin
              offset_reg_next = offset_reg + 8'd1;
              shift_byte_next = offset_reg + 8'd1;
              bit_count_next  = '0;
              phase_next      = PH_READ;
            end else begin
              phase_next    = PH_IDLE;
              res.bus_event = i2cso_pkg::EV_NACK;
            end
          end
          default: ;
        endcase
      end
    end else if (phase != PH_IDLE) begin
      stall_counter_next = stall_inc;
      if (stall_inc >= timeout_samples) begin
        res.bus_event      = i2cso_pkg::EV_TMO;
        offset_seen_next   = 1'b0;
        buffer_count_next  = '0;
        phase_next         = PH_IDLE;
        stall_counter_next = '0;
      end
    end
    if (phase_next == PH_IDLE) stall_counter_next = '0;

    if (phase_next == PH_ADDR_ACK || phase_next == PH_WRITE_ACK) begin
      res.sda_pull_low = 1'b1;
    end else if (phase_next == PH_READ) begin
      res.sda_pull_low = !shift_byte_next[7];
    end else begin
      res.sda_pull_low = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address   <= i2cso_pkg::SLAVE_ADDRESS_RST;
      timeout_samples <= i2cso_pkg::TIMEOUT_SAMPLES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        i2cso_pkg::CFG_SLAVE_ADDRESS:   slave_address   <= cfg_data[6:0];
        i2cso_pkg::CFG_TIMEOUT_SAMPLES: timeout_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  // bus state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_count      <= '0;
      shift_byte     <= '0;
      read_direction <= 1'b0;
      offset_reg     <= '0;
      offset_seen    <= 1'b0;
      start_offset   <= '0;
      buffer_count   <= '0;
      stall_counter  <= '0;
      last_lines     <= 2'b11;
    end else if (accept) begin
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      shift_byte     <= shift_byte_next;
      read_direction <= read_direction_next;
      offset_reg     <= offset_reg_next;
      offset_seen    <= offset_seen_next;
      start_offset   <= start_offset_next;
      buffer_count   <= buffer_count_next;
      stall_counter  <= stall_counter_next;
      last_lines     <= {scl, sda};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wbuf_we) write_buffer[wbuf_idx] <= shift_byte;
  end

  // output stage with skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_reg <= skid_valid ? skid_reg : res;
    end else if (accept) begin
      skid_reg <= res;
    end
  end

  assign sda_pull_low  = out_reg.sda_pull_low;
  assign bus_event     = out_reg.bus_event;
  assign commit_valid  = out_reg.commit_valid;
  assign commit_offset = out_reg.commit_offset;
  assign commit_count  = out_reg.commit_count;
  assign commit_bytes  = out_reg.commit_bytes;

endmodule

// ===== hdl/i2cso_checker.sv =====
// ----------------------------------------------------------------------------
// I2C slave offset register port checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module i2cso_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  bus_event,
  input logic        commit_valid,
  input logic [7:0]  commit_offset,
  input logic [2:0]  commit_count,
  input logic [31:0] commit_bytes
);

  // a commit only comes with a stop
  assert property (@(posedge clk) disable iff (rst)
    out_valid && commit_valid |-> bus_event == i2cso_pkg::EV_STOP)
    else $error("commit without stop event");

  // no commit leaves all commit fields clear
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !commit_valid |->
      commit_offset == 8'd0 && commit_count == 3'd0 && commit_bytes == 32'd0)
    else $error("commit fields set without commit");

  // a commit with a count of zero carries no commit bytes
  assert property (@(posedge clk) disable iff (rst)
    out_valid && commit_valid && commit_count == 3'd0 |-> commit_bytes == 32'd0)
    else $error("commit bytes beyond count");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> commit_count <= 3'(i2cso_pkg::MAX_WRITE_BYTES))
    else $error("commit count above buffer size");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bus_event)
      && $stable(commit_bytes))
    else $error("stalled result changed");

endmodule

bind i2c_slave_offset_register_port i2cso_checker u_i2cso_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .bus_event     (bus_event),
  .commit_valid  (commit_valid),
  .commit_offset (commit_offset),
  .commit_count  (commit_count),
  .commit_bytes  (commit_bytes)
);
